FILE: src/cspe_pkg.sv
// Shared types, constants and the bit-packing function of the seven-bit packet encoder.
package cspe_pkg;

    localparam int unsigned GROUP_BITS = 7;
    localparam int unsigned MAX_CODES  = 4;
    localparam logic [7:0]  END_MARK   = 8'h80;

    typedef logic [GROUP_BITS-1:0] t_group;

    // Result of pushing one byte into the bit stream.
    typedef struct packed {
        logic [1:0] n_groups;
        t_group     g0;
        t_group     g1;
        logic [5:0] bits;
        logic [2:0] cnt;
    } t_push;

    // Everything one input item produces: code groups plus the next state.
    typedef struct packed {
        logic [2:0]                   len;
        logic [MAX_CODES-1:0][6:0]    groups;
        logic                         last;
        logic [5:0]                   bits;
        logic [2:0]                   cnt;
        logic [7:0]                   sum;
    } t_pack;

    function automatic logic [5:0] f_low_mask(input logic [2:0] cnt);
        logic [6:0] m;
        m = (7'd1 << cnt) - 7'd1;
        return m[5:0];
    endfunction

    function automatic t_push f_push(input logic [5:0] bits, input logic [2:0] cnt,
                                     input logic [7:0] b);
        t_push      p;
        logic [2:0] c;
        logic [13:0] acc;
        logic [3:0] t;
        logic [3:0] rem;
        c   = (cnt > 3'd6) ? 3'd6 : cnt;
        acc = {bits & f_low_mask(c), b};
        t   = {1'b0, c} + 4'd8;
        p   = '0;
        if (t == 4'd14) begin
            p.n_groups = 2'd2;
            p.g0       = acc[13:7];
            p.g1       = acc[6:0];
            p.bits     = '0;
            p.cnt      = '0;
        end else begin
            rem        = t - 4'd7;
            p.n_groups = 2'd1;
            p.g0       = 7'(acc >> rem);
            p.g1       = '0;
            p.bits     = acc[5:0] & f_low_mask(rem[2:0]);
            p.cnt      = rem[2:0];
        end
        return p;
    endfunction

endpackage

FILE: src/cspe_if.sv
// Valid/ready channel interfaces for payload bytes in and code bytes out.
interface cspe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cspe_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       packet_end;

    modport source (output valid, output code_byte, output packet_end, input ready);
    modport sink   (input valid, input code_byte, input packet_end, output ready);
endinterface

FILE: src/cspe_pack.sv
// Combinational packer: turns one payload byte and the stream state into code groups.
module cspe_pack (
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    input  logic [5:0]     i_bits,
    input  logic [2:0]     i_cnt,
    input  logic [7:0]     i_sum,
    output cspe_pkg::t_pack o_pack
);
    import cspe_pkg::*;

    t_push      w_p1;
    t_push      w_p2;
    logic [7:0] w_sum;
    t_group     w_pad;
    t_group     w_cand [5];
    logic [4:0] w_cand_v;
    logic [2:0] w_pos;

    always_comb begin
        w_sum = i_sum + i_data_byte;
        w_p1  = f_push(i_bits, i_cnt, i_data_byte);
        w_p2  = f_push(w_p1.bits, w_p1.cnt, w_sum);
        // final partial group, zero padded at the low end
        w_pad = 7'({1'b0, w_p2.bits} << (3'd7 - w_p2.cnt));

        w_cand[0] = w_p1.g0;
        w_cand[1] = w_p1.g1;
        w_cand[2] = w_p2.g0;
        w_cand[3] = w_p2.g1;
        w_cand[4] = w_pad;
        w_cand_v[0] = 1'b1;
        w_cand_v[1] = (w_p1.n_groups == 2'd2);
        w_cand_v[2] = i_last_byte;
        w_cand_v[3] = i_last_byte && (w_p2.n_groups == 2'd2);
        w_cand_v[4] = i_last_byte && (w_p2.cnt != 3'd0);

        o_pack        = '0;
        o_pack.groups = '0;
        w_pos         = '0;
        for (int i = 0; i < 5; i++) begin
            if (w_cand_v[i] && (w_pos < 3'(MAX_CODES))) begin
                o_pack.groups[w_pos[1:0]] = w_cand[i];
                w_pos = w_pos + 3'd1;
            end
        end
        o_pack.len  = w_pos;
        o_pack.last = i_last_byte;
        if (i_last_byte) begin
            o_pack.bits = '0;
            o_pack.cnt  = '0;
            o_pack.sum  = '0;
        end else begin
            o_pack.bits = w_p1.bits;
            o_pack.cnt  = w_p1.cnt;
            o_pack.sum  = w_sum;
        end
    end

endmodule

FILE: src/checksum_seven_bit_packet_encoder_top.sv
// Top level of the seven-bit packet encoder: input register, packer and result buffer.
//
//  channel  dir  fields                     accepted when
//  i_in     in   data_byte[7:0] last_byte   valid && ready
//  o_out    out  code_byte[7:0] packet_end  valid && ready
//
// A payload byte waits in the input register, then its 1..4 code bytes load the
// result buffer together and leave one per cycle, while o_out is ready, through the
// single output port: 1 or 2 code bytes per middle byte, 3 or 4 on the last byte.
// The next item is taken while the buffer still drains; it loads as the last
// code byte leaves. Synchronous active-low reset clears the stream state, sum
// and all valid flags. A stalled output holds its code byte and backs up i_in.
module checksum_seven_bit_packet_encoder_top (
    input  logic i_clk,
    input  logic i_rst_n,
    cspe_byte_if.sink   i_in,
    cspe_code_if.source o_out
);
    import cspe_pkg::*;

    logic                      r_in_v;
    logic [7:0]                r_in_byte;
    logic                      r_in_last;
    logic [5:0]                r_bits;
    logic [2:0]                r_cnt;
    logic [7:0]                r_sum;
    logic [MAX_CODES-1:0][6:0] r_q;
    logic [MAX_CODES-1:0][6:0] n_q;
    logic [2:0]                r_len;
    logic [2:0]                n_len;
    logic                      r_end;
    logic                      w_pop;
    logic                      w_load;
    t_pack                     w_pack;

    cspe_pack u_pack (
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .i_bits      (r_bits),
        .i_cnt       (r_cnt),
        .i_sum       (r_sum),
        .o_pack      (w_pack)
    );

    assign w_pop  = o_out.valid && o_out.ready;
    assign w_load = r_in_v && ((r_len == 3'd0) || ((r_len == 3'd1) && w_pop));

    assign i_in.ready       = !r_in_v || w_load;
    assign o_out.valid      = (r_len != 3'd0);
    assign o_out.packet_end = r_end && (r_len == 3'd1);
    assign o_out.code_byte  = {o_out.packet_end, r_q[0]};

    always_comb begin
        n_q   = r_q;
        n_len = r_len;
        if (w_load) begin
            n_q   = w_pack.groups;
            n_len = w_pack.len;
        end else if (w_pop) begin
            for (int i = 0; i < MAX_CODES - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
            n_len = r_len - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_bits <= '0;
            r_cnt  <= '0;
            r_sum  <= '0;
            r_len  <= '0;
            r_end  <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_v <= 1'b1;
            end else if (w_load) begin
                r_in_v <= 1'b0;
            end
            r_len <= n_len;
            if (w_load) begin
                r_bits <= w_pack.bits;
                r_cnt  <= w_pack.cnt;
                r_sum  <= w_pack.sum;
                r_end  <= w_pack.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

`ifndef SYNTHESIS
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= 3'(MAX_CODES))
        else $error("result buffer count out of range");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd6)
        else $error("leftover bit count above six");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_in_last) |=> (r_sum == 8'd0) && (r_cnt == 3'd0) && r_end)
        else $error("stream state not cleared after packet end");

    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_len != 3'd0))
        else $error("loaded item produced no code byte");
`endif

endmodule
